// ===== sv/bts_pkg.sv =====
`default_nettype none
package bts_pkg;

   localparam int MaxNodes = 32;
   localparam int IdxW     = $clog2(MaxNodes);
   localparam int CntW     = IdxW + 1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_COUNT,
      ST_ROOTS,
      ST_SORT,
      ST_EMIT
   } state_type;

   typedef enum logic [2:0] {
      OP_HOLD,
      OP_CLEAR,
      OP_COUNT,
      OP_ROOTS,
      OP_SORT
   } cell_op_type;

   typedef struct packed {
      cell_op_type     op;
      logic [IdxW-1:0] scan_idx;
      logic [CntW-1:0] placed;
      logic [IdxW-1:0] emit_idx;
      logic            emit;
      logic            emit_last;
      logic            place;
      logic            busy;
   } ctl_type;

endpackage
`default_nettype wire

// ===== sv/bts_cell.sv =====
`default_nettype none
module bts_cell (
   input  logic                         clock,
   input  logic                         reset,
   input  bts_pkg::cell_op_type         op,
   input  logic                         wr_en,
   input  logic [bts_pkg::MaxNodes-1:0] wr_row,
   input  logic                         col_bit,
   input  logic                         used_bit,
   input  logic                         found_in,
   output logic [bts_pkg::MaxNodes-1:0] row,
   output logic                         found_out,
   output logic                         pick,
   output logic                         pend_zero
);
   import bts_pkg::*;

   logic [MaxNodes-1:0] row_ff, row_in;
   logic [CntW-1:0]     pend_ff, pend_in;
   logic                ready_ff, ready_in;

   assign pend_zero = (pend_ff == '0);
   assign pick      = ready_ff & ~found_in;
   assign found_out = found_in | ready_ff;
   assign row       = row_ff;

   always_comb begin
      row_in = wr_en ? wr_row : row_ff;
   end

   always_comb begin
      pend_in  = pend_ff;
      ready_in = ready_ff;
      case (op)
         OP_CLEAR: begin
            pend_in  = '0;
            ready_in = 1'b0;
         end
         OP_COUNT: begin
            if (col_bit) begin
               pend_in = pend_ff + CntW'(1);
            end
         end
         OP_ROOTS: begin
            ready_in = used_bit & pend_zero;
         end
         OP_SORT: begin
            if (pick) begin
               ready_in = 1'b0;
            end
            if (col_bit && !pend_zero) begin
               pend_in = pend_ff - CntW'(1);
               if (pend_ff == CntW'(1)) begin
                  ready_in = 1'b1;
               end
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      row_ff <= row_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff  <= '0;
         ready_ff <= 1'b0;
      end else begin
         pend_ff  <= pend_in;
         ready_ff <= ready_in;
      end
   end

endmodule
`default_nettype wire

// ===== sv/bts_ctrl.sv =====
`default_nettype none
module bts_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     accept,
   input  logic                     last_row,
   input  logic [bts_pkg::CntW-1:0] n_eff,
   input  logic                     any_ready,
   output bts_pkg::ctl_type         ctl
);
   import bts_pkg::*;

   state_type       state_ff, state_in;
   logic [IdxW-1:0] scan_ff, scan_in;
   logic [IdxW-1:0] emit_ff, emit_in;
   logic [CntW-1:0] placed_ff, placed_in;
   logic [CntW-1:0] n_last;
   logic            scan_last;
   logic            emit_last;
   logic            place;

   assign n_last    = n_eff - CntW'(1);
   assign scan_last = ({1'b0, scan_ff} == n_last);
   assign emit_last = ({1'b0, emit_ff} == n_last);
   assign place     = (state_ff == ST_SORT) && any_ready && (placed_ff != n_eff);

   // next state and counters
   always_comb begin
      state_in  = state_ff;
      scan_in   = scan_ff;
      emit_in   = emit_ff;
      placed_in = placed_ff;
      case (state_ff)
         ST_IDLE: begin
            scan_in = '0;
            emit_in = '0;
            if (accept && last_row) begin
               state_in = ST_COUNT;
            end
         end
         ST_COUNT: begin
            scan_in = scan_ff + IdxW'(1);
            if (scan_last) begin
               state_in = ST_ROOTS;
            end
         end
         ST_ROOTS: begin
            placed_in = '0;
            state_in  = ST_SORT;
         end
         ST_SORT: begin
            if (place) begin
               placed_in = placed_ff + CntW'(1);
            end else begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            emit_in = emit_ff + IdxW'(1);
            if (emit_last) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      ctl           = '0;
      ctl.op        = OP_HOLD;
      ctl.scan_idx  = scan_ff;
      ctl.placed    = placed_ff;
      ctl.emit_idx  = emit_ff;
      ctl.emit_last = emit_last;
      ctl.busy      = (state_ff != ST_IDLE);
      case (state_ff)
         ST_IDLE: begin
            if (accept && last_row) begin
               ctl.op = OP_CLEAR;
            end
         end
         ST_COUNT: ctl.op = OP_COUNT;
         ST_ROOTS: ctl.op = OP_ROOTS;
         ST_SORT: begin
            ctl.place = place;
            if (place) begin
               ctl.op = OP_SORT;
            end
         end
         ST_EMIT: ctl.emit = 1'b1;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         scan_ff   <= '0;
         emit_ff   <= '0;
         placed_ff <= '0;
      end else begin
         state_ff  <= state_in;
         scan_ff   <= scan_in;
         emit_ff   <= emit_in;
         placed_ff <= placed_in;
      end
   end

endmodule
`default_nettype wire

// ===== sv/bitmask_topological_sort_unit.sv =====
// Topological sort of a graph of up to 32 nodes given as successor bitmasks. Each request
// taken while idle loads one row. A request with req_last_row set raises busy and starts
// the sort over csr_node_count nodes (0 acts as 1, above 32 as 32): indegrees are counted
// one row at a time, the roots are marked, then one node is placed per cycle by the
// priority chain through the per-node cells (lowest ready index wins) until none is ready
// or all n are placed, then n results follow, one per cycle and one per position, each
// marked by rsp_valid for one cycle; the receiver cannot stall results, so it must take
// one every cycle. busy drops as the last result is registered; csr writes are taken only
// while busy is low.
`default_nettype none
module bitmask_topological_sort_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [4:0]  req_node_index,
   input  logic [31:0] req_successor_mask,
   input  logic        req_last_row,
   output logic        rsp_valid,
   output logic [4:0]  rsp_position,
   output logic [4:0]  rsp_chosen_node,
   output logic        rsp_unplaced,
   output logic        rsp_has_cycle,
   output logic [31:0] rsp_root_mask,
   output logic [31:0] rsp_leaf_mask,
   output logic        rsp_last_result,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [5:0]  csr_node_count
);
   import bts_pkg::*;

   ctl_type             ctl;
   logic                accept;
   logic [CntW-1:0]     count_ff, count_in;
   logic [CntW-1:0]     n_eff;
   logic [MaxNodes-1:0] used;
   logic [MaxNodes-1:0] rows [MaxNodes];
   logic [MaxNodes-1:0] picks;
   logic [MaxNodes-1:0] zeros;
   logic [MaxNodes:0]   found;
   logic [MaxNodes-1:0] sel_row;
   logic [MaxNodes-1:0] col_bits;
   logic [IdxW-1:0]     pick_idx;

   logic [MaxNodes-1:0] roots_ff, roots_in;
   logic [MaxNodes-1:0] leaves_ff, leaves_in;
   logic [IdxW-1:0]     order_ff [MaxNodes];

   logic                rsp_valid_ff, rsp_valid_in;
   logic [IdxW-1:0]     rsp_position_ff, rsp_position_in;
   logic [IdxW-1:0]     rsp_chosen_ff, rsp_chosen_in;
   logic                rsp_unplaced_ff, rsp_unplaced_in;
   logic                rsp_cycle_ff, rsp_cycle_in;
   logic [MaxNodes-1:0] rsp_root_ff, rsp_root_in;
   logic [MaxNodes-1:0] rsp_leaf_ff, rsp_leaf_in;
   logic                rsp_last_ff, rsp_last_in;

   assign busy      = ctl.busy;
   assign accept    = start & ~ctl.busy;
   assign csr_ready = ~ctl.busy;

   always_comb begin
      count_in = (csr_valid && csr_ready) ? csr_node_count : count_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= CntW'(MaxNodes);
      end else begin
         count_ff <= count_in;
      end
   end

   always_comb begin
      if (count_ff == '0) begin
         n_eff = CntW'(1);
      end else if (count_ff > CntW'(MaxNodes)) begin
         n_eff = CntW'(MaxNodes);
      end else begin
         n_eff = count_ff;
      end
   end

   bts_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .last_row  (req_last_row),
      .n_eff     (n_eff),
      .any_ready (found[MaxNodes]),
      .ctl       (ctl)
   );

   assign found[0] = 1'b0;

   for (genvar j = 0; j < MaxNodes; j++) begin : g_cell
      assign used[j]     = (CntW'(j) < n_eff);
      assign col_bits[j] = sel_row[j] & used[j];

      bts_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .op        (ctl.op),
         .wr_en     (accept && (req_node_index == IdxW'(j))),
         .wr_row    (req_successor_mask),
         .col_bit   (col_bits[j]),
         .used_bit  (used[j]),
         .found_in  (found[j]),
         .row       (rows[j]),
         .found_out (found[j+1]),
         .pick      (picks[j]),
         .pend_zero (zeros[j])
      );
   end

   // row broadcast: scanned row while counting, picked node's row while sorting
   always_comb begin
      sel_row  = '0;
      pick_idx = '0;
      if (ctl.op == OP_COUNT) begin
         sel_row = rows[ctl.scan_idx];
      end else begin
         for (int i = 0; i < MaxNodes; i++) begin
            if (picks[i]) begin
               sel_row  = sel_row | rows[i];
               pick_idx = pick_idx | IdxW'(i);
            end
         end
      end
   end

   always_comb begin
      roots_in  = roots_ff;
      leaves_in = leaves_ff;
      case (ctl.op)
         OP_CLEAR: leaves_in = '0;
         OP_COUNT: leaves_in[ctl.scan_idx] = ((sel_row & used) == '0);
         OP_ROOTS: roots_in = zeros & used;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      roots_ff  <= roots_in;
      leaves_ff <= leaves_in;
      if (ctl.place) begin
         order_ff[ctl.placed[IdxW-1:0]] <= pick_idx;
      end
   end

   always_comb begin
      rsp_valid_in    = ctl.emit;
      rsp_position_in = ctl.emit_idx;
      rsp_unplaced_in = ({1'b0, ctl.emit_idx} >= ctl.placed);
      rsp_chosen_in   = rsp_unplaced_in ? '0 : order_ff[ctl.emit_idx];
      rsp_cycle_in    = (ctl.placed != n_eff);
      rsp_root_in     = roots_ff;
      rsp_leaf_in     = leaves_ff;
      rsp_last_in     = ctl.emit_last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_position_ff <= rsp_position_in;
      rsp_chosen_ff   <= rsp_chosen_in;
      rsp_unplaced_ff <= rsp_unplaced_in;
      rsp_cycle_ff    <= rsp_cycle_in;
      rsp_root_ff     <= rsp_root_in;
      rsp_leaf_ff     <= rsp_leaf_in;
      rsp_last_ff     <= rsp_last_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_position    = rsp_position_ff;
   assign rsp_chosen_node = rsp_chosen_ff;
   assign rsp_unplaced    = rsp_unplaced_ff;
   assign rsp_has_cycle   = rsp_cycle_ff;
   assign rsp_root_mask   = rsp_root_ff;
   assign rsp_leaf_mask   = rsp_leaf_ff;
   assign rsp_last_result = rsp_last_ff;

endmodule
`default_nettype wire

// ===== sv/bts_checker.sv =====
`default_nettype none
module bts_checker (
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic        req_last_row,
   input logic        rsp_valid,
   input logic [4:0]  rsp_position,
   input logic [4:0]  rsp_chosen_node,
   input logic        rsp_unplaced,
   input logic        rsp_has_cycle,
   input logic        rsp_last_result
);

   // a sort always starts at position 0
   a_first_pos: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> rsp_position == 5'd0)
      else $error("first result not at position 0");

   // results of one sort come back to back with rising positions
   a_next_pos: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last_result |=>
         rsp_valid && rsp_position == 5'($past(rsp_position) + 5'd1))
      else $error("result sequence broken");

   // a last-row request keeps the block busy until the results are out
   a_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy && req_last_row |=> busy)
      else $error("not busy after last row");

   a_busy_emit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last_result |-> busy)
      else $error("idle while results pending");

   // an empty slot implies a cycle and a zero node
   a_unplaced: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_unplaced |-> rsp_has_cycle && rsp_chosen_node == 5'd0)
      else $error("unplaced slot inconsistent");

endmodule

bind bitmask_topological_sort_unit bts_checker u_bts_checker (.*);
`default_nettype wire
